### rtl/ptw_pkg.sv
// Shared types and constants for the four-level page table walker.
// Used by ptw_store and page_table_walker; depends on nothing else.
package ptw_pkg;

  localparam int ENTRY_W = 64;
  localparam int PA_W    = 52;
  localparam int VA_W    = 48;
  localparam int IDX_W   = 9;
  localparam int TIDX_W  = 12;

  // Entry flag bit positions.
  localparam int BIT_PRESENT = 0;
  localparam int BIT_LARGE   = 7;

  // Command codes carried in the input tuser.
  localparam logic CMD_WRITE     = 1'b0;
  localparam logic CMD_TRANSLATE = 1'b1;

  // Page size codes.
  localparam logic [1:0] SIZE_4K = 2'd0;
  localparam logic [1:0] SIZE_2M = 2'd1;
  localparam logic [1:0] SIZE_1G = 2'd2;

  // Level of the entry currently held in the read data register.
  localparam logic [1:0] LVL_4 = 2'd3;
  localparam logic [1:0] LVL_3 = 2'd2;
  localparam logic [1:0] LVL_2 = 2'd1;
  localparam logic [1:0] LVL_1 = 2'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_WRESP
  } ptw_state_t;

endpackage

### rtl/page_table_walker.sv
// Four-level page table walker over a 48-bit virtual address.
// A write item moves to ST_WRESP, where its result is registered once the output
// is free, then back to ST_IDLE for the next item. A translation reads one table
// entry per level through the single read port of the store, stepping down the
// levels in ST_WALK; no new item is taken until ST_IDLE. Reset clears the control
// state and root_table_base; the table store is not cleared and needs no sweep.
module page_table_walker #(
  parameter int TABLE_WORDS = 4096  // power of two, 512 to 65536
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [51:0]   cfg_wdata,      // root_table_base
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [127:0]  s_axis_tdata,   // virtual_address, table_index, entry_value
  input  logic          s_axis_tuser,   // command
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [55:0]   m_axis_tdata,   // physical_address, page_size
  output logic          m_axis_tuser    // fault
);
  import ptw_pkg::*;

  localparam int AW = $clog2(TABLE_WORDS);

  ptw_state_t state, state_next;

  logic [51:12]        root_base;
  logic [VA_W-1:0]     va;
  logic [1:0]          lvl;
  logic [1:0]          lvl_next;

  logic [VA_W-1:0]     in_va;
  logic [TIDX_W-1:0]   in_tidx;
  logic [ENTRY_W-1:0]  in_entry;
  logic [AW+TIDX_W-1:0] in_tidx_ext;

  logic                s_fire;
  logic                out_free;
  logic                out_load;

  logic                ram_we;
  logic                ram_re;
  logic [AW-1:0]       ram_wr_addr;
  logic [AW-1:0]       ram_rd_addr;
  logic [ENTRY_W-1:0]  ram_rdata_q;
  logic [ENTRY_W-1:0]  entry;

  logic                present;
  logic                large_page;
  logic                walk_done;
  logic [IDX_W-1:0]    next_idx;
  logic [PA_W-1:0]     res_pa;
  logic                res_fault;
  logic [1:0]          res_size;

  logic [PA_W-1:0]     m_pa;
  logic [1:0]          m_size;
  logic                m_fault;
  logic                m_valid;

  // Store word of entry idx in the table at base: the pointer keeps only bits
  // 51..12, so the sum never carries and the index is a plain concatenation.
  function automatic logic [AW-1:0] word_addr(input logic [51:12] base,
                                               input logic [IDX_W-1:0] idx);
    logic [40+IDX_W-1:0] full;
    full = {base, idx};
    return full[AW-1:0];
  endfunction

  assign in_va       = s_axis_tdata[47:0];
  assign in_tidx     = s_axis_tdata[59:48];
  assign in_entry    = s_axis_tdata[123:60];
  assign in_tidx_ext = {{AW{1'b0}}, in_tidx};

  assign s_fire   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid || m_axis_tready;

  assign entry      = ram_rdata_q;
  assign present    = entry[BIT_PRESENT];
  assign large_page = entry[BIT_LARGE];

  ptw_store #(
    .WORDS (TABLE_WORDS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (in_entry),
    .re      (ram_re),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rdata_q)
  );

  // Evaluate the entry that arrived from the store.
  always_comb begin
    walk_done = !present || lvl == LVL_1 ||
                ((lvl == LVL_3 || lvl == LVL_2) && large_page);
    res_fault = !present;
    res_pa    = '0;
    res_size  = SIZE_4K;
    if (present) begin
      if (lvl == LVL_3 && large_page) begin
        res_pa   = {entry[51:30], va[29:0]};
        res_size = SIZE_1G;
      end else if (lvl == LVL_2 && large_page) begin
        res_pa   = {entry[51:21], va[20:0]};
        res_size = SIZE_2M;
      end else if (lvl == LVL_1) begin
        res_pa   = {entry[51:12], va[11:0]};
        res_size = SIZE_4K;
      end
    end
    case (lvl)
      LVL_4:   next_idx = va[38:30];
      LVL_3:   next_idx = va[29:21];
      default: next_idx = va[20:12];
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = (s_axis_tuser == CMD_WRITE) ? ST_WRESP : ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_done && out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_WRESP: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_wr_addr   = in_tidx_ext[AW-1:0];
    ram_rd_addr   = word_addr(root_base, in_va[47:39]);
    out_load      = 1'b0;
    lvl_next      = lvl;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        ram_we        = s_axis_tvalid && s_axis_tuser == CMD_WRITE;
        ram_re        = s_axis_tvalid && s_axis_tuser == CMD_TRANSLATE;
        lvl_next      = LVL_4;
      end
      ST_WALK: begin
        ram_rd_addr = word_addr(entry[51:12], next_idx);
        if (walk_done) begin
          out_load = out_free;
        end else begin
          ram_re   = 1'b1;
          lvl_next = lvl - 2'd1;
        end
      end
      ST_WRESP: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      root_base <= '0;
      m_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        root_base <= cfg_wdata[51:12];
      end
      if (out_load) begin
        m_valid <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lvl <= lvl_next;
    if (s_fire) begin
      va <= in_va;
    end
    if (out_load) begin
      if (state == ST_WRESP) begin
        m_pa    <= '0;
        m_size  <= SIZE_4K;
        m_fault <= 1'b0;
      end else begin
        m_pa    <= res_pa;
        m_size  <= res_size;
        m_fault <= res_fault;
      end
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {2'b00, m_size, m_pa};
  assign m_axis_tuser  = m_fault;

`ifndef SYNTHESIS
  a_walk_steps_down: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && !walk_done) |=> (state == ST_WALK && lvl == $past(lvl) - 2'd1))
    else $error("walk level did not step down after a table read");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("table store written and read in the same cycle");

  a_fault_clean: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 56'd0))
    else $error("faulting item carries a nonzero address or size");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !out_load)
    else $error("result register overwritten while an item waits");
`endif

endmodule

### rtl/ptw_store.sv
// Table store of the page table walker: one write port, one read port,
// registered read data. Depends on ptw_pkg.
module ptw_store #(
  parameter int WORDS = 4096,
  parameter int AW    = 12
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               wr_addr,
  input  logic [ptw_pkg::ENTRY_W-1:0] wr_data,
  input  logic                        re,
  input  logic [AW-1:0]               rd_addr,
  output logic [ptw_pkg::ENTRY_W-1:0] rd_data
);
  import ptw_pkg::*;

  logic [ENTRY_W-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
